// File: design/cbm_pkg.sv
// shared types, codes and bank helper functions for the cartridge bank mapper
`timescale 1ns / 1ps

package cbm_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] CFG_MAPPER   = 2'd0;
    localparam logic [1:0] CFG_PRG_SIZE = 2'd1;
    localparam logic [1:0] CFG_CHR_SIZE = 2'd2;

    localparam logic [7:0] MAPPER_SERIAL = 8'd1;
    localparam logic [7:0] MAPPER_UXROM  = 8'd2;
    localparam logic [7:0] MAPPER_CNROM  = 8'd3;
    localparam logic [7:0] MAPPER_AXROM  = 8'd7;

    localparam int unsigned PRG_SWITCHED = 4;
    localparam int unsigned SERIAL_REGS  = 4;

    localparam logic [4:0] SERIAL_CTRL_RESET = 5'h0C;
    localparam logic [2:0] SHIFT_LEN         = 3'd5;
    localparam logic [2:0] PRG_SIZE_MAX      = 3'd5;
    localparam logic [2:0] CHR_SIZE_MAX      = 3'd4;

    // prg bank modes of the serial control register
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    // low six bits of the bank start for the last 16k bank
    localparam logic [5:0] PRG_LAST_START = 6'h3E;

    localparam logic [1:0] MIRROR_SINGLE_0  = 2'd0;
    localparam logic [1:0] MIRROR_SINGLE_1  = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL  = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTL = 2'd3;

    typedef struct packed {
        logic        is_prg_ram;
        logic [18:0] prg_offset;
        logic [16:0] chr_low_base;
        logic [16:0] chr_high_base;
        logic [3:0]  nametable;
    } t_result;

    function automatic logic [5:0] prg_mask(input logic [2:0] size_log2);
        logic [2:0] l;
        l = (size_log2 > PRG_SIZE_MAX) ? PRG_SIZE_MAX : size_log2;
        return 6'((7'd2 << l) - 7'd1);
    endfunction

    function automatic logic [6:0] chr_mask(input logic [2:0] size_log2);
        logic [2:0] l;
        l = (size_log2 > CHR_SIZE_MAX) ? CHR_SIZE_MAX : size_log2;
        return 7'((8'd8 << l) - 8'd1);
    endfunction

    function automatic logic [5:0] prg_page(input logic [5:0] start, input logic [1:0] k,
                                            input logic [5:0] mask);
        return (start + {4'd0, k}) & mask;
    endfunction

    // bit m gives the page of nametable slot m
    function automatic logic [3:0] mirror_sel(input logic [1:0] mode);
        logic [3:0] sel;
        unique case (mode)
            MIRROR_SINGLE_0:  sel = 4'b0000;
            MIRROR_SINGLE_1:  sel = 4'b1111;
            MIRROR_VERTICAL:  sel = 4'b1010;
            MIRROR_HORIZONTL: sel = 4'b1100;
        endcase
        return sel;
    endfunction

endpackage

// File: design/cartridge_bank_mapper.sv
// top level of the cartridge bank mapper: bank state, translation and output buffer
`timescale 1ns / 1ps

// cartridge bank mapper for mapper numbers 1, 2, 3 and 7; others keep the fixed mapping
// input channel: one beat per cpu access (read, write or init of the default mapping),
//   handshake i_in_valid / o_in_ready
// output channel: one beat per input beat, handshake o_out_valid / i_out_ready, carrying
//   the translated prg offset (or work ram offset), both chr bases and nametable pages
//   as they stand after the access has updated the bank state
// result: registered into the output register, or into the skid register while a result waits
// throughput: one beat per cycle while o_in_ready is high; the bank state is updated
//   in the same cycle as the translation, so the next beat sees it straight away
// stall: a two-entry output buffer (output register plus skid register) lets one more
//   beat in while a result waits; o_in_ready drops only when both entries are full
// configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index (0 mapper
//   number, 1 prg size, 2 chr size); user writes only while the block is idle, unchecked
// reset: synchronous, active low; clears both buffer entries and restores the default
//   mapping, mirroring 0,1,0,1 and the serial registers

module cartridge_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_cpu_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_rom_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_prg_ram,
    output logic [18:0] o_prg_offset,
    output logic [16:0] o_chr_low_base,
    output logic [16:0] o_chr_high_base,
    output logic        o_nametable_0,
    output logic        o_nametable_1,
    output logic        o_nametable_2,
    output logic        o_nametable_3
);

    logic [7:0] r_mapper;
    logic [2:0] r_prg_size;
    logic [2:0] r_chr_size;

    // prg windows 0x8000-0xFFFF; the lower windows always hold banks 0,1,0,1
    logic [5:0] r_prg_page [cbm_pkg::PRG_SWITCHED];
    logic [5:0] n_prg_page [cbm_pkg::PRG_SWITCHED];
    logic [6:0] r_chr_low, n_chr_low;
    logic [6:0] r_chr_high, n_chr_high;
    logic [3:0] r_nametable, n_nametable;
    logic [4:0] r_serial [cbm_pkg::SERIAL_REGS];
    logic [4:0] n_serial [cbm_pkg::SERIAL_REGS];
    logic [2:0] r_shift_count, n_shift_count;
    logic [4:0] r_shift_data, n_shift_data;

    logic [5:0] pmask;
    logic [6:0] cmask;
    logic       in_fire;
    logic       out_fire;
    logic       apply;
    logic [4:0] shift_acc;
    logic [2:0] count_inc;
    logic [5:0] start16;
    logic [5:0] start32;
    logic [6:0] chr_start;
    logic [1:0] chr_bank;
    logic [5:0] win_page;
    cbm_pkg::t_result n_result;

    logic             r_out_valid;
    logic             r_skid_valid;
    cbm_pkg::t_result r_out;
    cbm_pkg::t_result r_skid;

    assign pmask    = cbm_pkg::prg_mask(r_prg_size);
    assign cmask    = cbm_pkg::chr_mask(r_chr_size);
    assign o_in_ready = !r_skid_valid;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper   <= '0;
            r_prg_size <= '0;
            r_chr_size <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cbm_pkg::CFG_MAPPER:   r_mapper   <= i_cfg_wdata;
                cbm_pkg::CFG_PRG_SIZE: r_prg_size <= i_cfg_wdata[2:0];
                cbm_pkg::CFG_CHR_SIZE: r_chr_size <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // bank state update for the beat being taken
    always_comb begin
        n_prg_page    = r_prg_page;
        n_chr_low     = r_chr_low;
        n_chr_high    = r_chr_high;
        n_nametable   = r_nametable;
        n_serial      = r_serial;
        n_shift_count = r_shift_count;
        n_shift_data  = r_shift_data;
        apply         = 1'b0;
        shift_acc     = r_shift_data | (5'(i_write_data[0]) << r_shift_count);
        count_inc     = r_shift_count + 3'd1;
        start16       = {i_write_data[4:0], 1'b0};
        start32       = {1'b0, i_write_data[2:0], 2'b00};
        chr_bank      = i_write_data[1:0] & i_rom_byte[1:0];
        chr_start     = {2'b00, chr_bank, 3'b000};

        if (in_fire) begin
            if (i_op == cbm_pkg::OP_WRITE && i_cpu_address[15]) begin
                unique case (r_mapper)
                    cbm_pkg::MAPPER_SERIAL: begin
                        if (i_write_data[7]) begin
                            n_serial[0]   = r_serial[0] | cbm_pkg::SERIAL_CTRL_RESET;
                            n_shift_count = '0;
                            n_shift_data  = '0;
                            apply         = 1'b1;
                        end else if (count_inc == cbm_pkg::SHIFT_LEN) begin
                            n_serial[i_cpu_address[14:13]] = shift_acc;
                            n_shift_count = '0;
                            n_shift_data  = '0;
                            apply         = 1'b1;
                        end else begin
                            n_shift_count = count_inc;
                            n_shift_data  = shift_acc;
                        end
                    end
                    cbm_pkg::MAPPER_UXROM: begin
                        n_prg_page[0] = cbm_pkg::prg_page(start16, 2'd0, pmask);
                        n_prg_page[1] = cbm_pkg::prg_page(start16, 2'd1, pmask);
                    end
                    cbm_pkg::MAPPER_CNROM: begin
                        n_chr_low  = chr_start & cmask;
                        n_chr_high = (chr_start + 7'd4) & cmask;
                    end
                    cbm_pkg::MAPPER_AXROM: begin
                        for (int k = 0; k < cbm_pkg::PRG_SWITCHED; k++) begin
                            n_prg_page[k] = cbm_pkg::prg_page(start32, 2'(k), pmask);
                        end
                        n_nametable = {4{i_write_data[4]}};
                    end
                    default: ;
                endcase
            end else if (i_op == cbm_pkg::OP_INIT) begin
                n_chr_low     = '0;
                n_chr_high    = 7'd4 & cmask;
                n_prg_page[0] = cbm_pkg::prg_page(6'd0, 2'd0, pmask);
                n_prg_page[1] = cbm_pkg::prg_page(6'd0, 2'd1, pmask);
                n_prg_page[2] = cbm_pkg::prg_page(cbm_pkg::PRG_LAST_START, 2'd0, pmask);
                n_prg_page[3] = cbm_pkg::prg_page(cbm_pkg::PRG_LAST_START, 2'd1, pmask);
            end

            if (apply) begin
                n_nametable = cbm_pkg::mirror_sel(n_serial[0][1:0]);
                if (n_serial[0][4]) begin
                    n_chr_low  = {n_serial[1], 2'b00} & cmask;
                    n_chr_high = {n_serial[2], 2'b00} & cmask;
                end else begin
                    n_chr_low  = {n_serial[1][4:1], 3'b000} & cmask;
                    n_chr_high = {n_serial[1][4:1], 3'b100} & cmask;
                end
                unique case (n_serial[0][3:2])
                    cbm_pkg::PRG_MODE_FIX_LOW: begin
                        n_prg_page[0] = cbm_pkg::prg_page(6'd0, 2'd0, pmask);
                        n_prg_page[1] = cbm_pkg::prg_page(6'd0, 2'd1, pmask);
                        n_prg_page[2] = cbm_pkg::prg_page({1'b0, n_serial[3][3:0], 1'b0},
                                                          2'd0, pmask);
                        n_prg_page[3] = cbm_pkg::prg_page({1'b0, n_serial[3][3:0], 1'b0},
                                                          2'd1, pmask);
                    end
                    cbm_pkg::PRG_MODE_FIX_HIGH: begin
                        n_prg_page[0] = cbm_pkg::prg_page({1'b0, n_serial[3][3:0], 1'b0},
                                                          2'd0, pmask);
                        n_prg_page[1] = cbm_pkg::prg_page({1'b0, n_serial[3][3:0], 1'b0},
                                                          2'd1, pmask);
                        n_prg_page[2] = cbm_pkg::prg_page(cbm_pkg::PRG_LAST_START, 2'd0, pmask);
                        n_prg_page[3] = cbm_pkg::prg_page(cbm_pkg::PRG_LAST_START, 2'd1, pmask);
                    end
                    default: begin
                        for (int k = 0; k < cbm_pkg::PRG_SWITCHED; k++) begin
                            n_prg_page[k] = cbm_pkg::prg_page({1'b0, n_serial[3][3:1], 2'b00},
                                                              2'(k), pmask);
                        end
                    end
                endcase
            end
        end
    end

    // translation against the updated state
    always_comb begin
        if (i_cpu_address[15]) begin
            win_page = n_prg_page[i_cpu_address[14:13]];
        end else begin
            win_page = {5'd0, i_cpu_address[13]};
        end
        n_result.is_prg_ram = (i_cpu_address[15:13] == 3'd3);
        if (n_result.is_prg_ram) begin
            n_result.prg_offset = {6'd0, i_cpu_address[12:0]};
        end else begin
            n_result.prg_offset = {win_page, i_cpu_address[12:0]};
        end
        n_result.chr_low_base  = {n_chr_low, 10'd0};
        n_result.chr_high_base = {n_chr_high, 10'd0};
        n_result.nametable     = n_nametable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_page    <= '{6'd0, 6'd1, 6'd0, 6'd1};
            r_chr_low     <= 7'd0;
            r_chr_high    <= 7'd4;
            r_nametable   <= 4'b1010;
            r_serial      <= '{cbm_pkg::SERIAL_CTRL_RESET, 5'd0, 5'd0, 5'd0};
            r_shift_count <= '0;
            r_shift_data  <= '0;
        end else begin
            r_prg_page    <= n_prg_page;
            r_chr_low     <= n_chr_low;
            r_chr_high    <= n_chr_high;
            r_nametable   <= n_nametable;
            r_serial      <= n_serial;
            r_shift_count <= n_shift_count;
            r_shift_data  <= n_shift_data;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_prg_ram    = r_out.is_prg_ram;
    assign o_prg_offset    = r_out.prg_offset;
    assign o_chr_low_base  = r_out.chr_low_base;
    assign o_chr_high_base = r_out.chr_high_base;
    assign o_nametable_0   = r_out.nametable[0];
    assign o_nametable_1   = r_out.nametable[1];
    assign o_nametable_2   = r_out.nametable[2];
    assign o_nametable_3   = r_out.nametable[3];

endmodule

// File: bench/tb.sv
// self-checking testbench for the cartridge bank mapper with its own bank state predictor
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT  = 200;
    localparam int unsigned PHASES          = 30;
    localparam int unsigned BEATS_PER_PHASE = 48;
    localparam int unsigned QUIET_PHASES    = 4;

    class bank_scoreboard;
        logic [7:0] mapper_no;
        logic [2:0] prg_log2;
        logic [2:0] chr_log2;
        logic [5:0] prg_bank [8];
        logic [6:0] chr_bank [8];
        logic [3:0] nt_page;
        logic [4:0] serial [4];
        logic [2:0] shift_cnt;
        logic [4:0] shift_reg;
        cbm_pkg::t_result expected_q [$];
        int unsigned mismatches;
        int unsigned compared;

        function new();
            mapper_no  = '0;
            prg_log2   = '0;
            chr_log2   = '0;
            nt_page    = 4'b1010;
            serial     = '{cbm_pkg::SERIAL_CTRL_RESET, 5'd0, 5'd0, 5'd0};
            shift_cnt  = '0;
            shift_reg  = '0;
            mismatches = 0;
            compared   = 0;
            default_banks();
        endfunction

        function void configure(logic [1:0] idx, logic [7:0] val);
            case (idx)
                cbm_pkg::CFG_MAPPER:   mapper_no = val;
                cbm_pkg::CFG_PRG_SIZE: prg_log2 = val[2:0];
                cbm_pkg::CFG_CHR_SIZE: chr_log2 = val[2:0];
                default: ;
            endcase
        endfunction

        // map a run of 8k windows to consecutive banks, wrapped to the rom size
        function void fill_prg(int unsigned pages, int unsigned first, logic [31:0] bank);
            logic [31:0] start;
            logic [31:0] mask;
            int unsigned k;
            start = bank * pages;
            mask = (32'd2 << ((prg_log2 > cbm_pkg::PRG_SIZE_MAX) ? cbm_pkg::PRG_SIZE_MAX
                                                                 : prg_log2)) - 32'd1;
            for (k = 0; k < pages && first + k < 8; k++)
                prg_bank[first + k] = 6'((start + k) & mask);
        endfunction

        function void fill_chr(int unsigned pages, int unsigned first, logic [31:0] bank);
            logic [31:0] start;
            logic [31:0] mask;
            int unsigned k;
            start = bank * pages;
            mask = (32'd8 << ((chr_log2 > cbm_pkg::CHR_SIZE_MAX) ? cbm_pkg::CHR_SIZE_MAX
                                                                 : chr_log2)) - 32'd1;
            for (k = 0; k < pages && first + k < 8; k++)
                chr_bank[first + k] = 7'((start + k) & mask);
        endfunction

        function void default_banks();
            int unsigned v;
            fill_chr(8, 0, 32'd0);
            for (v = 0; v < 4; v++)
                fill_prg(2, 2 * v, (v == 3) ? 32'hFFFF_FFFF : 32'd0);
        endfunction

        function void note_input(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                                 logic [7:0] rom);
            cbm_pkg::t_result want;
            logic [4:0] r0;
            logic [4:0] r1;
            logic [4:0] r2;
            logic [4:0] r3;
            if (op == cbm_pkg::OP_WRITE && addr[15]) begin
                case (mapper_no)
                    cbm_pkg::MAPPER_SERIAL: begin
                        if (data[7]) begin
                            serial[0] = serial[0] | cbm_pkg::SERIAL_CTRL_RESET;
                            shift_cnt = '0;
                            shift_reg = '0;
                        end else begin
                            shift_reg = shift_reg | (5'(data[0]) << shift_cnt);
                            shift_cnt = shift_cnt + 3'd1;
                            if (shift_cnt == cbm_pkg::SHIFT_LEN) begin
                                serial[addr[14:13]] = shift_reg;
                                shift_cnt = '0;
                                shift_reg = '0;
                            end
                        end
                        // shift state cleared means a register load or a serial reset
                        if (shift_cnt == 3'd0) begin
                            r0 = serial[0];
                            r1 = serial[1];
                            r2 = serial[2];
                            r3 = serial[3];
                            case (r0[1:0])
                                cbm_pkg::MIRROR_SINGLE_0: nt_page = 4'b0000;
                                cbm_pkg::MIRROR_SINGLE_1: nt_page = 4'b1111;
                                cbm_pkg::MIRROR_VERTICAL: nt_page = 4'b1010;
                                default:                  nt_page = 4'b1100;
                            endcase
                            if (r0[4]) begin
                                fill_chr(4, 0, 32'(r1));
                                fill_chr(4, 4, 32'(r2));
                            end else begin
                                fill_chr(4, 0, 32'({r1[4:1], 1'b0}));
                                fill_chr(4, 4, 32'({r1[4:1], 1'b1}));
                            end
                            case (r0[3:2])
                                cbm_pkg::PRG_MODE_FIX_LOW: begin
                                    fill_prg(2, 4, 32'd0);
                                    fill_prg(2, 6, 32'(r3[3:0]));
                                end
                                cbm_pkg::PRG_MODE_FIX_HIGH: begin
                                    fill_prg(2, 4, 32'(r3[3:0]));
                                    fill_prg(2, 6, 32'hFFFF_FFFF);
                                end
                                default: fill_prg(4, 4, 32'(r3[3:1]));
                            endcase
                        end
                    end
                    cbm_pkg::MAPPER_UXROM: fill_prg(2, 4, 32'(data));
                    cbm_pkg::MAPPER_CNROM: fill_chr(8, 0, 32'(data[1:0] & rom[1:0]));
                    cbm_pkg::MAPPER_AXROM: begin
                        fill_prg(4, 4, 32'(data[2:0]));
                        nt_page = {4{data[4]}};
                    end
                    default: ;
                endcase
            end else if (op == cbm_pkg::OP_INIT) begin
                default_banks();
            end
            want.is_prg_ram    = (addr[15:13] == 3'd3);
            want.prg_offset    = want.is_prg_ram ? {6'd0, addr[12:0]}
                                                 : {prg_bank[addr[15:13]], addr[12:0]};
            want.chr_low_base  = {chr_bank[0], 10'd0};
            want.chr_high_base = {chr_bank[4], 10'd0};
            want.nametable     = nt_page;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [18:0] want, logic [18:0] seen);
            if (want !== seen) begin
                mismatches++;
                $display("%t: %s expected 0x%0h got 0x%0h", $time, name, want, seen);
            end
        endfunction

        function void check_result(cbm_pkg::t_result seen);
            cbm_pkg::t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%t: result beat with nothing outstanding", $time);
                return;
            end
            want = expected_q.pop_front();
            compared++;
            compare_field("is_prg_ram", 19'(want.is_prg_ram), 19'(seen.is_prg_ram));
            compare_field("prg_offset", want.prg_offset, seen.prg_offset);
            compare_field("chr_low_base", 19'(want.chr_low_base), 19'(seen.chr_low_base));
            compare_field("chr_high_base", 19'(want.chr_high_base), 19'(seen.chr_high_base));
            compare_field("nametable", 19'(want.nametable), 19'(seen.nametable));
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [15:0] i_cpu_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_rom_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_is_prg_ram;
    logic [18:0] o_prg_offset;
    logic [16:0] o_chr_low_base;
    logic [16:0] o_chr_high_base;
    logic        o_nametable_0;
    logic        o_nametable_1;
    logic        o_nametable_2;
    logic        o_nametable_3;

    bank_scoreboard sb;
    bit          sender_gaps;
    bit          receiver_stalls;
    int unsigned beats_sent;
    int unsigned setups;

    cartridge_bank_mapper u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_cpu_address   (i_cpu_address),
        .i_write_data    (i_write_data),
        .i_rom_byte      (i_rom_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_prg_ram    (o_is_prg_ram),
        .o_prg_offset    (o_prg_offset),
        .o_chr_low_base  (o_chr_low_base),
        .o_chr_high_base (o_chr_high_base),
        .o_nametable_0   (o_nametable_0),
        .o_nametable_1   (o_nametable_1),
        .o_nametable_2   (o_nametable_2),
        .o_nametable_3   (o_nametable_3)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
                               input logic [7:0] data, input logic [7:0] rom);
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_cpu_address <= addr;
        i_write_data  <= data;
        i_rom_byte    <= rom;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, addr, data, rom);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.configure(idx, val);
    endtask

    // only while idle: every result back, then a quiet pause
    task automatic load_bank_setup(input logic [7:0] mapper, input logic [7:0] prg_val,
                                   input logic [7:0] chr_val);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        write_reg(cbm_pkg::CFG_MAPPER, mapper);
        write_reg(cbm_pkg::CFG_PRG_SIZE, prg_val);
        write_reg(cbm_pkg::CFG_CHR_SIZE, chr_val);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        setups++;
    endtask

    task automatic noise_access();
        int unsigned r;
        logic [1:0]  op;
        r = $urandom_range(0, 99);
        op = (r < 45) ? cbm_pkg::OP_READ : (r < 80) ? cbm_pkg::OP_WRITE :
             (r < 90) ? cbm_pkg::OP_INIT : OP_UNDEF;
        send_access(op, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // five single-bit writes, reads mixed in, last address picks the register
    task automatic serial_load();
        logic [15:0] target;
        int unsigned b;
        target = {1'b1, 15'($urandom)};
        for (b = 0; b < 5; b++) begin
            if ($urandom_range(0, 3) == 0)
                send_access(cbm_pkg::OP_READ, 16'($urandom), 8'($urandom), 8'($urandom));
            send_access(cbm_pkg::OP_WRITE,
                        ($urandom_range(0, 4) == 0) ? {1'b1, 15'($urandom)} : target,
                        {1'b0, 7'($urandom)}, 8'($urandom));
        end
    endtask

    initial begin
        cbm_pkg::t_result seen;
        int unsigned      stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.is_prg_ram    = o_is_prg_ram;
                seen.prg_offset    = o_prg_offset;
                seen.chr_low_base  = o_chr_low_base;
                seen.chr_high_base = o_chr_high_base;
                seen.nametable     = {o_nametable_3, o_nametable_2, o_nametable_1, o_nametable_0};
                sb.check_result(seen);
            end
            if (stall == 0 && receiver_stalls && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 6);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned r;
        bit          quiet;
        logic [7:0]  mapper;
        logic [2:0]  prg_l;
        logic [2:0]  chr_l;
        sb = new();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        beats_sent      = 0;
        setups          = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= cbm_pkg::CFG_MAPPER;
        i_cfg_wdata   <= 8'd0;
        i_in_valid    <= 1'b0;
        i_op          <= cbm_pkg::OP_READ;
        i_cpu_address <= 16'd0;
        i_write_data  <= 8'd0;
        i_rom_byte    <= 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fixed mapping straight out of reset, address extremes, work ram edges
        send_access(cbm_pkg::OP_READ, 16'h0000, 8'h00, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
        send_access(cbm_pkg::OP_READ, 16'h6000, 8'h00, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00, 8'h00);
        send_access(OP_UNDEF, 16'h8123, 8'hFF, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF, 8'hFF);
        // oversized rom sizes clamp
        load_bank_setup(cbm_pkg::MAPPER_UXROM, 8'd7, 8'd7);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF, 8'h00);
        send_access(cbm_pkg::OP_READ, 16'hC000, 8'h00, 8'h00);
        send_access(cbm_pkg::OP_INIT, 16'hE000, 8'h00, 8'h00);
        // bus conflict: written byte anded with rom byte
        load_bank_setup(cbm_pkg::MAPPER_CNROM, 8'd0, 8'd4);
        send_access(cbm_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 8'h02);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'h01, 8'hFE);
        send_access(cbm_pkg::OP_READ, 16'h1000, 8'h00, 8'h00);
        load_bank_setup(cbm_pkg::MAPPER_AXROM, 8'd5, 8'd0);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'h17, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h4020, 8'hFF, 8'hFF);
        load_bank_setup(cbm_pkg::MAPPER_SERIAL, 8'd3, 8'd2);
        send_access(cbm_pkg::OP_WRITE, 16'hE000, 8'h01, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'hE000, 8'h00, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'hE000, 8'h01, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'hE000, 8'h01, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'hE000, 8'h00, 8'h00);
        // serial reset part way through a load
        send_access(cbm_pkg::OP_WRITE, 16'hA000, 8'h01, 8'h00);
        send_access(cbm_pkg::OP_WRITE, 16'h8000, 8'h80, 8'h00);

        for (phase = 0; phase < PHASES; phase++) begin
            quiet = (phase >= PHASES - QUIET_PHASES);
            case (phase)
                0: begin mapper = cbm_pkg::MAPPER_SERIAL; prg_l = 3'd0; chr_l = 3'd0; end
                1: begin mapper = cbm_pkg::MAPPER_UXROM;  prg_l = 3'd5; chr_l = 3'd4; end
                2: begin mapper = cbm_pkg::MAPPER_CNROM;  prg_l = 3'd7; chr_l = 3'd7; end
                3: begin mapper = cbm_pkg::MAPPER_AXROM;  prg_l = 3'd3; chr_l = 3'd2; end
                default: begin
                    r = $urandom_range(0, 9);
                    case (r)
                        4: mapper = cbm_pkg::MAPPER_UXROM;
                        5: mapper = cbm_pkg::MAPPER_CNROM;
                        6: mapper = cbm_pkg::MAPPER_AXROM;
                        7: mapper = 8'($urandom);
                        8: mapper = 8'd0;
                        9: mapper = 8'hFF;
                        default: mapper = cbm_pkg::MAPPER_SERIAL;
                    endcase
                    prg_l = 3'($urandom);
                    chr_l = 3'($urandom);
                end
            endcase
            sender_gaps     = !quiet && $urandom_range(0, 4) != 0;
            receiver_stalls = !quiet && $urandom_range(0, 4) != 0;
            load_bank_setup(mapper, {5'($urandom), prg_l}, {5'($urandom), chr_l});
            phase_start = beats_sent;
            while (beats_sent < phase_start + BEATS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (mapper == cbm_pkg::MAPPER_SERIAL) begin
                    if (r < 70)
                        serial_load();
                    else if (r < 78)
                        send_access(cbm_pkg::OP_WRITE, {1'b1, 15'($urandom)},
                                    {1'b1, 7'($urandom)}, 8'($urandom));
                    else
                        noise_access();
                end else if (r < 55) begin
                    send_access(cbm_pkg::OP_WRITE, {1'b1, 15'($urandom)}, 8'($urandom),
                                8'($urandom));
                end else begin
                    noise_access();
                end
            end
        end

        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("covered %0d cpu accesses across %0d bank setups of mapper type and rom size",
                 beats_sent, setups);
        $display("%0d translations compared, %0d mismatches", sb.compared, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
